// ===== design/phcl_pkg.sv =====
// Shared types and constants for the pose heuristic cost lookup.
// No dependencies; every other file of the block imports this package.
package phcl_pkg;

  localparam int OFS_W      = 12;
  localparam int HD_W       = 4;
  localparam int COST_W     = 30;
  localparam int RES_W      = 32;
  localparam int CFG_W      = 24;
  localparam int OMODE_W    = 3;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_MAP_WIDTH     = 16;
  localparam int DEF_MAP_HEIGHT    = 16;
  localparam int DEF_HEADINGS      = 16;
  localparam int DEF_SENTINEL_COST = 1000000000;

  localparam logic [OMODE_W-1:0] OMODE_RESET = 3'd5;
  localparam logic [CFG_W-1:0]   TRANS_RESET = 24'd256000;
  localparam logic [CFG_W-1:0]   ROT_RESET   = 24'd100531;

  // border projection and distance widths
  localparam int POS_W   = 22;
  localparam int DIV_W   = 20;
  localparam int REL_W   = 14;
  localparam int D2_W    = 28;
  localparam int SQ_IN_W = D2_W + 16;
  localparam int SQ_RT_W = SQ_IN_W / 2;
  localparam int ROOT_W  = SQ_RT_W + 1;
  localparam int STEP_W  = 7;

  localparam logic ITEM_LOAD  = 1'b0;
  localparam logic ITEM_QUERY = 1'b1;

  typedef enum logic [OMODE_W-1:0] {
    OM_MAX         = 3'd0,
    OM_INFINITE    = 3'd1,
    OM_ASSERT      = 3'd2,
    OM_ZERO        = 3'd3,
    OM_EUCLID_PRE  = 3'd4,
    OM_EUCLID_APP  = 3'd5
  } omode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_OF_MAP_MODE = 2'd0,
    CFG_TRANS_MS        = 2'd1,
    CFG_ROT_MS          = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOKUP, ST_PREP_Y, ST_DIV_Y, ST_CHECK, ST_DIV_X, ST_PROJ,
    ST_SQUARE, ST_SQRT_GO, ST_SQRT_WAIT, ST_LIN_MUL, ST_LIN_ADD, ST_SCAN,
    ST_SCAN_LAST, ST_EMIT
  } state_e;

endpackage

// ===== design/phcl_in_if.sv =====
// Input channel of the cost lookup: valid/ready plus one load or query beat.
// Depends on phcl_pkg.
interface phcl_in_if import phcl_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [OFS_W-1:0]  offset_x;
  logic signed [OFS_W-1:0]  offset_y;
  logic [HD_W-1:0]          start_heading;
  logic [HD_W-1:0]          end_heading;
  logic [COST_W-1:0]        entry_cost;

  modport source (output valid, mode, offset_x, offset_y, start_heading, end_heading,
                  entry_cost, input ready);
  modport sink   (input valid, mode, offset_x, offset_y, start_heading, end_heading,
                  entry_cost, output ready);
endinterface

// ===== design/phcl_out_if.sv =====
// Result channel of the cost lookup: valid/ready plus one cost beat.
// Depends on phcl_pkg.
interface phcl_out_if import phcl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] cost;
  logic             outside_map;
  logic             assert_error;

  modport source (output valid, cost, outside_map, assert_error, input ready);
  modport sink   (input valid, cost, outside_map, assert_error, output ready);
endinterface

// ===== design/phcl_div.sv =====
// Iterative signed divider (truncating), one quotient bit per cycle.
// Depends on phcl_pkg.
module phcl_div import phcl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIV_W:0]   num_i,
  input  logic signed [OFS_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [DIV_W:0]   quo_o
);
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [OFS_W-1:0] den_q, rem_q;
  logic [DIV_W-1:0] acc_q;
  logic [OFS_W:0]   trial;
  logic [DIV_W:0]   num_mag;
  logic [OFS_W-1:0] den_mag;
  logic             fits;

  assign num_mag = num_i[DIV_W] ? (DIV_W+1)'(-num_i) : num_i;
  assign den_mag = den_i[OFS_W-1] ? OFS_W'(-den_i) : den_i;
  assign trial   = {rem_q, acc_q[DIV_W-1]};
  assign fits    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DIV_W] ^ den_i[OFS_W-1];
      den_q <= den_mag;
      rem_q <= '0;
      acc_q <= num_mag[DIV_W-1:0];
    end else if (busy_q) begin
      rem_q <= fits ? OFS_W'(trial - {1'b0, den_q}) : trial[OFS_W-1:0];
      acc_q <= {acc_q[DIV_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
endmodule

// ===== design/phcl_sqrt.sv =====
// Iterative square root rounded up, one root bit per cycle.
// Depends on phcl_pkg.
module phcl_sqrt import phcl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SQ_IN_W-1:0] rad_i,
  output logic               done_o,
  output logic [ROOT_W-1:0]  root_o
);
  localparam int CNT_W = $clog2(SQ_RT_W + 1);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SQ_IN_W-1:0] rad_q;
  logic [SQ_RT_W+1:0] rem_q;
  logic [SQ_RT_W-1:0] root_q;
  logic [SQ_RT_W+1:0] rem_sh, trial;
  logic               fits;

  assign rem_sh = {rem_q[SQ_RT_W-1:0], rad_q[SQ_IN_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(SQ_RT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQ_IN_W-3:0], 2'b00};
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[SQ_RT_W-2:0], fits};
    end
  end

  // round up when a remainder is left
  assign done_o = done_q;
  assign root_o = {1'b0, root_q} + ROOT_W'(rem_q != '0);
endmodule

// ===== design/phcl_table.sv =====
// Cost table memory: one write port, one registered read port.
// Depends on phcl_pkg.
module phcl_table import phcl_pkg::*; #(
  parameter int DEPTH = DEF_HEADINGS * DEF_HEADINGS * DEF_MAP_WIDTH * DEF_MAP_HEIGHT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [COST_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [COST_W-1:0] rdata_o
);
  logic [COST_W-1:0] mem [DEPTH];
  logic [COST_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/pose_heuristic_cost_lookup.sv =====
// Pose heuristic cost lookup. Load beats write the table from idle; a query inside
// the map reads the table, an out-of-map query in a fixed mode answers from the
// configured mode, and a Euclidean query runs up to two divisions, a square root
// and one table read per heading through the single read port.
// One item is worked on at a time; a new item is taken while a result waits.
// Reset (rst_ni, async, active low) clears control and config; table contents stay.
module pose_heuristic_cost_lookup import phcl_pkg::*; #(
  parameter int MAP_WIDTH     = DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT    = DEF_MAP_HEIGHT,
  parameter int HEADINGS      = DEF_HEADINGS,
  parameter int SENTINEL_COST = DEF_SENTINEL_COST
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  phcl_in_if.sink              item_i,
  phcl_out_if.source           result_o
);
  localparam int DEPTH  = HEADINGS * HEADINGS * MAP_WIDTH * MAP_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int HIW    = $clog2(HEADINGS);
  localparam int XW     = $clog2(MAP_WIDTH);
  localparam int YW     = $clog2(MAP_HEIGHT);
  localparam int HALF_W = MAP_WIDTH / 2;
  localparam int HALF_H = MAP_HEIGHT / 2;
  localparam logic [COST_W-1:0] INF_C = COST_W'(SENTINEL_COST);

  state_e state_q, state_d;

  // configuration
  logic [OMODE_W-1:0] omode_q;
  logic [CFG_W-1:0]   trans_q, rot_cfg_q;
  logic [COST_W-1:0]  largest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omode_q   <= OMODE_RESET;
      trans_q   <= TRANS_RESET;
      rot_cfg_q <= ROT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_OUT_OF_MAP_MODE) omode_q   <= cfg_data_i[OMODE_W-1:0];
      if (cfg_idx_i == CFG_TRANS_MS)        trans_q   <= cfg_data_i;
      if (cfg_idx_i == CFG_ROT_MS)          rot_cfg_q <= cfg_data_i;
    end
  end

  // input decode
  logic in_fire, in_inside, hd_ok;
  int   ix_in, iy_in, cx_in, cy_in;
  logic [AW-1:0] in_addr;

  assign in_fire = item_i.valid && item_i.ready;

  always_comb begin
    ix_in = int'(item_i.offset_x) + HALF_W;
    iy_in = int'(item_i.offset_y) + HALF_H;
    hd_ok = (int'(item_i.start_heading) < HEADINGS) && (int'(item_i.end_heading) < HEADINGS);
    in_inside = (ix_in >= 0) && (ix_in < MAP_WIDTH) && (iy_in >= 0) && (iy_in < MAP_HEIGHT)
                && hd_ok;
    in_addr = AW'(((int'(item_i.start_heading) * MAP_WIDTH + ix_in) * MAP_HEIGHT + iy_in)
                  * HEADINGS + int'(item_i.end_heading));
    cx_in = (ix_in < 0) ? 0 : ((ix_in > MAP_WIDTH - 1) ? MAP_WIDTH - 1 : ix_in);
    cy_in = (iy_in < 0) ? 0 : ((iy_in > MAP_HEIGHT - 1) ? MAP_HEIGHT - 1 : iy_in);
  end

  // datapath registers
  logic signed [OFS_W-1:0] dx_q, dy_q;
  logic [HD_W-1:0]         s_q, e_q;
  logic signed [POS_W-1:0] cdx_q, cdy_q, yx_q, px_q, py_q;
  logic [XW-1:0]           bx_q;
  logic [YW-1:0]           by_q;
  logic signed [REL_W-1:0] rx_q, ry_q;
  logic [D2_W-1:0]         d2_q;
  logic [ROOT_W+CFG_W-1:0] prod_q;
  logic [RES_W-1:0]        lin_q, rot_q, best_q;
  logic [HIW-1:0]          hi_q;
  logic                    pend_q, first_q;
  logic [RES_W-1:0]        res_cost_q;
  logic                    res_oom_q, res_aerr_q;
  logic                    out_valid_q, out_oom_q, out_aerr_q;
  logic [RES_W-1:0]        out_cost_q;

  // shared units
  logic                    div_start, div_done, sqrt_start, sqrt_done;
  logic signed [DIV_W:0]   div_num, div_quo;
  logic signed [OFS_W-1:0] div_den;
  logic signed [POS_W+OFS_W-1:0] prod_y, prod_x;
  logic [ROOT_W-1:0]       root;
  logic                    need_x;

  assign prod_y = cdx_q * dy_q;
  assign prod_x = cdy_q * dx_q;
  assign need_x = (yx_q > 0 && yx_q > cdy_q) || (yx_q < 0 && yx_q < cdy_q);

  phcl_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  phcl_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i (sqrt_start),
    .rad_i   ({d2_q, 16'h0000}),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // table
  logic              tbl_we, tbl_re;
  logic [AW-1:0]     tbl_raddr, scan_addr;
  logic [COST_W-1:0] tbl_rdata;

  phcl_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
    .clk_i,
    .we_i    (tbl_we),
    .waddr_i (in_addr),
    .wdata_i (item_i.entry_cost),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // heading scan terms
  logic             prepend;
  int               other_h, diff_h, step_i;
  logic [STEP_W-1:0]       steps;
  logic [STEP_W+CFG_W-1:0] rot_prod;
  logic [RES_W-1:0]        rot_val, stretch, cand;

  assign prepend = (omode_q == OM_EUCLID_PRE);

  always_comb begin
    other_h = prepend ? int'(s_q) : int'(e_q);
    diff_h  = (other_h > int'(hi_q)) ? other_h - int'(hi_q) : int'(hi_q) - other_h;
    step_i  = (HEADINGS - diff_h < diff_h) ? HEADINGS - diff_h : diff_h;
    steps   = STEP_W'(step_i);
    rot_prod = steps * rot_cfg_q;
    rot_val  = RES_W'((rot_prod + (STEP_W+CFG_W)'(255)) >> 8);
    if (prepend)
      scan_addr = AW'(((int'(hi_q) * MAP_WIDTH + int'(bx_q)) * MAP_HEIGHT + int'(by_q))
                      * HEADINGS + int'(e_q));
    else
      scan_addr = AW'(((int'(s_q) * MAP_WIDTH + int'(bx_q)) * MAP_HEIGHT + int'(by_q))
                      * HEADINGS + int'(hi_q));
    stretch = (lin_q > rot_q) ? lin_q : rot_q;
    cand    = RES_W'(tbl_rdata) + stretch;
  end

  // projection terms
  int bx_i, by_i;
  always_comb begin
    bx_i = int'(px_q) + HALF_W;
    by_i = int'(py_q) + HALF_H;
    bx_i = (bx_i < 0) ? 0 : ((bx_i > MAP_WIDTH - 1) ? MAP_WIDTH - 1 : bx_i);
    by_i = (by_i < 0) ? 0 : ((by_i > MAP_HEIGHT - 1) ? MAP_HEIGHT - 1 : by_i);
  end

  logic out_load;
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || result_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && item_i.mode == ITEM_QUERY) begin
          if (in_inside) state_d = ST_LOOKUP;
          else if (omode_q == OM_MAX || omode_q == OM_INFINITE || omode_q == OM_ASSERT ||
                   omode_q == OM_ZERO || !hd_ok) state_d = ST_EMIT;
          else state_d = ST_PREP_Y;
        end
      end
      ST_LOOKUP:    state_d = ST_EMIT;
      ST_PREP_Y:    state_d = (dx_q == '0) ? ST_CHECK : ST_DIV_Y;
      ST_DIV_Y:     if (div_done) state_d = ST_CHECK;
      ST_CHECK:     state_d = (need_x && dy_q != '0) ? ST_DIV_X : ST_PROJ;
      ST_DIV_X:     if (div_done) state_d = ST_PROJ;
      ST_PROJ:      state_d = ST_SQUARE;
      ST_SQUARE:    state_d = ST_SQRT_GO;
      ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_done) state_d = ST_LIN_MUL;
      ST_LIN_MUL:   state_d = ST_LIN_ADD;
      ST_LIN_ADD:   state_d = ST_SCAN;
      ST_SCAN:      if (hi_q == HIW'(HEADINGS - 1)) state_d = ST_SCAN_LAST;
      ST_SCAN_LAST: state_d = ST_EMIT;
      ST_EMIT:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_i.ready = (state_q == ST_IDLE);
    div_start    = 1'b0;
    div_num      = prod_y[DIV_W:0];
    div_den      = dx_q;
    sqrt_start   = 1'b0;
    tbl_we       = 1'b0;
    tbl_re       = 1'b0;
    tbl_raddr    = in_addr;
    case (state_q)
      ST_IDLE: begin
        tbl_we = in_fire && item_i.mode == ITEM_LOAD && in_inside;
        tbl_re = in_fire && item_i.mode == ITEM_QUERY && in_inside;
      end
      ST_PREP_Y:  div_start = (dx_q != '0);
      ST_CHECK: begin
        div_start = need_x && dy_q != '0;
        div_num   = prod_x[DIV_W:0];
        div_den   = dy_q;
      end
      ST_SQRT_GO: sqrt_start = 1'b1;
      ST_SCAN: begin
        tbl_re    = 1'b1;
        tbl_raddr = scan_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      largest_q   <= COST_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (tbl_we && item_i.entry_cost != INF_C && item_i.entry_cost > largest_q)
        largest_q <= item_i.entry_cost;
      if (out_load) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cost_q <= res_cost_q;
      out_oom_q  <= res_oom_q;
      out_aerr_q <= res_aerr_q;
    end
    case (state_q)
      ST_IDLE: begin
        dx_q       <= item_i.offset_x;
        dy_q       <= item_i.offset_y;
        s_q        <= item_i.start_heading;
        e_q        <= item_i.end_heading;
        cdx_q      <= POS_W'(cx_in - HALF_W);
        cdy_q      <= POS_W'(cy_in - HALF_H);
        res_oom_q  <= !in_inside;
        res_aerr_q <= 1'b0;
        case (omode_q)
          OM_MAX:      res_cost_q <= RES_W'(largest_q);
          OM_INFINITE: res_cost_q <= RES_W'(INF_C);
          OM_ASSERT: begin
            res_cost_q <= '0;
            res_aerr_q <= !in_inside;
          end
          OM_ZERO:     res_cost_q <= '0;
          default:     res_cost_q <= RES_W'(INF_C);
        endcase
      end
      ST_LOOKUP: res_cost_q <= RES_W'(tbl_rdata);
      ST_PREP_Y: if (dx_q == '0) yx_q <= cdy_q;
      ST_DIV_Y:  if (div_done) yx_q <= POS_W'(div_quo);
      ST_CHECK: begin
        if (need_x) begin
          py_q <= cdy_q;
          px_q <= cdx_q;
        end else begin
          px_q <= cdx_q;
          py_q <= yx_q;
        end
      end
      ST_DIV_X:  if (div_done) px_q <= POS_W'(div_quo);
      ST_PROJ: begin
        bx_q <= XW'(bx_i);
        by_q <= YW'(by_i);
        rx_q <= REL_W'(int'(dx_q) - (bx_i - HALF_W));
        ry_q <= REL_W'(int'(dy_q) - (by_i - HALF_H));
      end
      ST_SQUARE:  d2_q <= D2_W'(rx_q * rx_q) + D2_W'(ry_q * ry_q);
      ST_SQRT_WAIT: if (sqrt_done) prod_q <= root * trans_q;
      ST_LIN_MUL: lin_q <= RES_W'(({1'b0, prod_q} + (ROOT_W+CFG_W+1)'(65535)) >> 16);
      ST_LIN_ADD: begin
        hi_q    <= '0;
        pend_q  <= 1'b0;
        first_q <= 1'b1;
      end
      ST_SCAN: begin
        rot_q  <= rot_val;
        pend_q <= 1'b1;
        hi_q   <= hi_q + HIW'(1);
        if (pend_q) begin
          first_q <= 1'b0;
          if (first_q || cand < best_q) best_q <= cand;
        end
      end
      ST_SCAN_LAST: res_cost_q <= (cand < best_q) ? cand : best_q;
      default: ;
    endcase
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.cost         = out_cost_q;
  assign result_o.outside_map  = out_oom_q;
  assign result_o.assert_error = out_aerr_q;

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> state_q == ST_IDLE) else $error("table write outside idle");

  a_largest_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    largest_q != '0) else $error("running maximum dropped to zero");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_valid_q) |=> out_valid_q)
    else $error("result not moved to output register");

  a_div_only_in_proj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (state_q == ST_PREP_Y || state_q == ST_CHECK))
    else $error("divider started outside projection");
endmodule

// ===== tb/sv/pose_heuristic_cost_lookup_tb.sv =====
// Self-checking bench for pose_heuristic_cost_lookup: loads and queries driven in
// random bursts, results predicted by a local cost model and compared per beat.
// Depends on phcl_pkg, phcl_in_if, phcl_out_if and the block itself.
module pose_heuristic_cost_lookup_tb;
  import phcl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MW     = DEF_MAP_WIDTH;
  localparam int MH     = DEF_MAP_HEIGHT;
  localparam int NH     = DEF_HEADINGS;
  localparam int INF    = DEF_SENTINEL_COST;
  localparam int HALF_W = MW / 2;
  localparam int HALF_H = MH / 2;
  localparam int CELLS  = NH * MW * MH * NH;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic                    mode;
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic [HD_W-1:0]         sh;
    logic [HD_W-1:0]         eh;
    logic [COST_W-1:0]       ec;
  } beat_t;

  typedef struct {
    logic [RES_W-1:0] cost;
    logic             outside;
    logic             aerr;
  } cost_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  phcl_in_if  in_ch ();
  phcl_out_if out_ch ();

  pose_heuristic_cost_lookup dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (in_ch),
    .result_o   (out_ch)
  );

  // cost model state
  logic [COST_W-1:0] cost_tab [CELLS];
  logic [COST_W-1:0] largest_cost = 1;
  logic [OMODE_W-1:0] om_cfg    = OMODE_RESET;
  logic [CFG_W-1:0]   trans_cfg = TRANS_RESET;
  logic [CFG_W-1:0]   rot_cfg   = ROT_RESET;

  bit            filled [CELLS];
  beat_t         pending_beats [$];
  cost_result_t  due_costs [$];
  int            fail_cnt = 0;
  int            idle_cycles = 0;
  int            stall_pct = 0;
  bit            hold_go = 1'b0;
  bit            hold_done = 1'b0;
  int            hold_left = 0;
  int            gap_left = 0;
  int            burst_left = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int tab_at(int s, int x, int y, int e);
    return ((s * MW + x) * MH + y) * NH + e;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned sqrt_up(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return (n != 0) ? r + 1 : r;
  endfunction

  // time to cover a straight stretch while turning from heading a to b
  function automatic longint unsigned stretch_ms(int ddx, int ddy, int a, int b);
    longint unsigned d2, r, lin, rot;
    int diff;
    d2   = longint'(ddx) * ddx + longint'(ddy) * ddy;
    r    = sqrt_up(d2 << 16);
    lin  = (r * trans_cfg + 65535) >> 16;
    diff = a > b ? a - b : b - a;
    diff = diff % NH;
    if (NH - diff < diff) diff = NH - diff;
    rot  = (longint'(diff) * rot_cfg + 255) >> 8;
    return lin > rot ? lin : rot;
  endfunction

  // project an outside offset onto the map border, table coordinates
  function automatic void border_cell(int dx, int dy, output int bx, output int by);
    int cdx, cdy, yx, xy, px, py;
    cdx = clampi(dx + HALF_W, 0, MW - 1) - HALF_W;
    cdy = clampi(dy + HALF_H, 0, MH - 1) - HALF_H;
    yx  = (dx == 0) ? cdy : (cdx * dy) / dx;
    xy  = (dy == 0) ? cdx : (cdy * dx) / dy;
    px  = cdx;
    py  = yx;
    if ((py > 0 && py > cdy) || (py < 0 && py < cdy)) begin
      px = xy;
      py = cdy;
    end
    bx = clampi(px + HALF_W, 0, MW - 1);
    by = clampi(py + HALF_H, 0, MH - 1);
  endfunction

  function automatic longint unsigned euclid_ms(int dx, int dy, int s, int e, bit pre);
    int bx, by, rx, ry;
    longint unsigned c, best;
    best = 0;
    if (s >= NH || e >= NH) return INF;
    border_cell(dx, dy, bx, by);
    rx = dx - (bx - HALF_W);
    ry = dy - (by - HALF_H);
    for (int i = 0; i < NH; i++) begin
      if (pre) c = cost_tab[tab_at(i, bx, by, e)] + stretch_ms(rx, ry, s, i);
      else     c = cost_tab[tab_at(s, bx, by, i)] + stretch_ms(rx, ry, i, e);
      if (i == 0 || c < best) best = c;
    end
    return best;
  endfunction

  // apply one accepted beat to the model; queries queue their expected cost
  function automatic void apply_beat(beat_t b);
    int dx, dy, x, y, s, e;
    bit in_map;
    longint unsigned c;
    cost_result_t r;
    dx = int'(b.ox);
    dy = int'(b.oy);
    x  = dx + HALF_W;
    y  = dy + HALF_H;
    s  = b.sh;
    e  = b.eh;
    in_map = x >= 0 && x < MW && y >= 0 && y < MH && s < NH && e < NH;
    if (b.mode == ITEM_LOAD) begin
      if (in_map) begin
        cost_tab[tab_at(s, x, y, e)] = b.ec;
        if (b.ec != INF && b.ec > largest_cost) largest_cost = b.ec;
      end
      return;
    end
    r.aerr = 1'b0;
    if (in_map) begin
      c = cost_tab[tab_at(s, x, y, e)];
    end else begin
      case (om_cfg)
        OM_MAX:       c = largest_cost;
        OM_INFINITE:  c = INF;
        OM_ASSERT: begin
          c = 0;
          r.aerr = 1'b1;
        end
        OM_ZERO:      c = 0;
        OM_EUCLID_PRE: c = euclid_ms(dx, dy, s, e, 1'b1);
        default:      c = euclid_ms(dx, dy, s, e, 1'b0);
      endcase
    end
    if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
    r.cost    = c[RES_W-1:0];
    r.outside = !in_map;
    due_costs.insert(due_costs.size(), r);
  endfunction

  function automatic int unsigned rand_cost();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return INF;
      2:       return $urandom_range(0, 1000);
      default: return $urandom_range(0, INF);
    endcase
  endfunction

  function automatic void push_beat(bit m, int ox, int oy, int sh, int eh,
                                    int unsigned ec);
    beat_t b;
    b.mode = m;
    b.ox   = OFS_W'(ox);
    b.oy   = OFS_W'(oy);
    b.sh   = HD_W'(sh);
    b.eh   = HD_W'(eh);
    b.ec   = COST_W'(ec);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // queue a beat, preceded by loads for any table entry it would read unwritten
  function automatic void add_beat(bit m, int ox, int oy, int sh, int eh,
                                   int unsigned ec);
    int x, y, bx, by, idx;
    bit in_map, pre;
    x = ox + HALF_W;
    y = oy + HALF_H;
    in_map = x >= 0 && x < MW && y >= 0 && y < MH;
    if (m == ITEM_LOAD) begin
      if (in_map) filled[tab_at(sh, x, y, eh)] = 1'b1;
    end else if (in_map) begin
      idx = tab_at(sh, x, y, eh);
      if (!filled[idx]) begin
        push_beat(ITEM_LOAD, ox, oy, sh, eh, rand_cost());
        filled[idx] = 1'b1;
      end
    end else if (om_cfg >= OM_EUCLID_PRE) begin
      pre = (om_cfg == OM_EUCLID_PRE);
      border_cell(ox, oy, bx, by);
      for (int i = 0; i < NH; i++) begin
        idx = pre ? tab_at(i, bx, by, eh) : tab_at(sh, bx, by, i);
        if (!filled[idx]) begin
          push_beat(ITEM_LOAD, bx - HALF_W, by - HALF_H, pre ? i : sh, pre ? eh : i,
                    rand_cost());
          filled[idx] = 1'b1;
        end
      end
    end
    push_beat(m, ox, oy, sh, eh, ec);
  endfunction

  function automatic int rand_ofs(int cls);
    case (cls)
      0:       return $urandom_range(0, MW - 1) - HALF_W;
      1:       return $urandom_range(0, 39) - 20;
      default: return $urandom_range(0, 4095) - 2048;
    endcase
  endfunction

  // queue about n beats, the table fills included
  function automatic void add_random(int n);
    int cls, base;
    base = pending_beats.size();
    while (pending_beats.size() < base + n) begin
      if ($urandom_range(0, 9) < 4) begin
        cls = ($urandom_range(0, 9) < 8) ? 0 : 2;
        add_beat(ITEM_LOAD, rand_ofs(cls), rand_ofs(cls), $urandom_range(0, NH - 1),
                 $urandom_range(0, NH - 1), rand_cost());
      end else begin
        cls = $urandom_range(0, 9);
        cls = cls < 4 ? 0 : (cls < 7 ? 1 : 2);
        add_beat(ITEM_QUERY, rand_ofs(cls), rand_ofs(cls), $urandom_range(0, NH - 1),
                 $urandom_range(0, NH - 1), $urandom_range(0, (1 << 30) - 1));
      end
    end
  endfunction

  task automatic set_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (idx)
      CFG_OUT_OF_MAP_MODE: om_cfg = v[OMODE_W-1:0];
      CFG_TRANS_MS:        trans_cfg = v;
      default:             rot_cfg = v;
    endcase
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || due_costs.size() != 0 || in_ch.valid)
      @(posedge clk_i);
    // loads leave no result; let the longest query path finish as well
    repeat (150) @(posedge clk_i);
  endtask

  // sender: bursts of beats separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    beat_t b;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        b = pending_beats.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= b.mode;
        in_ch.offset_x      <= b.ox;
        in_ch.offset_y      <= b.oy;
        in_ch.start_heading <= b.sh;
        in_ch.end_heading   <= b.eh;
        in_ch.entry_cost    <= b.ec;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 500;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    beat_t b;
    cost_result_t exp_r;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        b.mode = in_ch.mode;
        b.ox   = in_ch.offset_x;
        b.oy   = in_ch.offset_y;
        b.sh   = in_ch.start_heading;
        b.eh   = in_ch.end_heading;
        b.ec   = in_ch.entry_cost;
        apply_beat(b);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (due_costs.size() == 0) begin
          $error("unexpected result beat: cost %0d", out_ch.cost);
          fail_cnt++;
        end else begin
          exp_r = due_costs.pop_front();
          if (out_ch.cost !== exp_r.cost) begin
            $error("cost: expected %0d, got %0d", exp_r.cost, out_ch.cost);
            fail_cnt++;
          end
          if (out_ch.outside_map !== exp_r.outside) begin
            $error("outside_map: expected %0b, got %0b", exp_r.outside, out_ch.outside_map);
            fail_cnt++;
          end
          if (out_ch.assert_error !== exp_r.aerr) begin
            $error("assert_error: expected %0b, got %0b", exp_r.aerr, out_ch.assert_error);
            fail_cnt++;
          end
        end
      end
      if (moved || (pending_beats.size() == 0 && due_costs.size() == 0 && !in_ch.valid))
      begin
        idle_cycles = 0;
      end else if (++idle_cycles >= STALL_LIMIT) begin
        $display("** pose_heuristic_cost_lookup: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [OMODE_W-1:0] modes [10] = '{3'd5, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
                                       3'd7, 3'd4};
    logic [CFG_W-1:0] tr, ro;
    in_ch.valid         = 1'b0;
    in_ch.mode          = ITEM_LOAD;
    in_ch.offset_x      = '0;
    in_ch.offset_y      = '0;
    in_ch.start_heading = '0;
    in_ch.end_heading   = '0;
    in_ch.entry_cost    = '0;
    out_ch.ready        = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_OUT_OF_MAP_MODE;
    cfg_data_i          = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corners, sentinel, overwrite, ignored loads, border projections
    add_beat(ITEM_LOAD,  0,  0,  0,  0, 500);
    add_beat(ITEM_LOAD, -8, -8,  0, 15, 0);
    add_beat(ITEM_LOAD,  7,  7, 15,  0, INF);
    add_beat(ITEM_LOAD,  7, -8,  3,  4, INF - 1);
    add_beat(ITEM_LOAD,  0,  0,  0,  0, 10);
    add_beat(ITEM_LOAD, 2047, -2048, 5, 5, 77);
    add_beat(ITEM_LOAD, -9,  0,  1,  1, 99);
    add_beat(ITEM_QUERY, 0,  0,  0,  0, 0);
    add_beat(ITEM_QUERY, -8, -8, 0, 15, 0);
    add_beat(ITEM_QUERY, 7,  7, 15,  0, '1);
    add_beat(ITEM_QUERY, 7, -8,  3,  4, 0);
    add_beat(ITEM_QUERY, 2047, 2047, 15, 15, 0);
    add_beat(ITEM_QUERY, -2048, -2048, 0, 0, 0);
    add_beat(ITEM_QUERY, 0, 2047, 0, 8, 0);
    add_beat(ITEM_QUERY, -2048, 0, 8, 0, 0);
    add_beat(ITEM_QUERY, 8, 0, 3, 12, 0);
    add_beat(ITEM_QUERY, 0, -9, 12, 3, 0);
    add_beat(ITEM_QUERY, 100, -37, 1, 14, 0);

    for (int p = 0; p < 10; p++) begin
      if (p > 0) begin
        case (p)
          2:       begin tr = '0; ro = '0; end
          4:       begin tr = '1; ro = '1; end
          9:       begin tr = '1; ro = '0; end
          default: begin
            tr = CFG_W'($urandom_range(0, 1 << 20));
            ro = CFG_W'($urandom_range(0, 1 << 18));
          end
        endcase
        set_reg(CFG_OUT_OF_MAP_MODE, modes[p]);
        set_reg(CFG_TRANS_MS, tr);
        set_reg(CFG_ROT_MS, ro);
        cfg_we_i <= 1'b0;
      end
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 70);
      if (p == 5) hold_go = 1'b1;
      add_random(92);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("** pose_heuristic_cost_lookup: PASSED **");
    end else begin
      $display("** pose_heuristic_cost_lookup: FAILED **");
    end
    $finish;
  end

endmodule
